### src/rlfe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rlfe_pkg;

  // store depth default
  localparam int MAX_LEDS_DEF = 32;

  // field widths
  localparam int IDX_W   = 6;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LED_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MA_PER_CH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BUDGET    = 2'd2;

  // configuration reset values
  localparam logic [5:0]  LED_COUNT_RST = 6'd32;
  localparam logic [7:0]  MA_PER_CH_RST = 8'd20;
  localparam logic [15:0] BUDGET_RST    = 16'd25000;

  // item kinds
  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_RENDER = 1'b1;

  // result status codes
  localparam logic [2:0] ST_WRITE_OK = 3'd0;
  localparam logic [2:0] ST_LED      = 3'd1;
  localparam logic [2:0] ST_TERM     = 3'd2;
  localparam logic [2:0] ST_OVER     = 3'd3;
  localparam logic [2:0] ST_RANGE    = 3'd4;

  // bit pair to serial byte
  localparam logic [7:0] PAIR_CODE [4] = '{8'h88, 8'h8C, 8'hC8, 8'hCC};

  typedef struct packed {
    logic       kind;
    logic [5:0] led_index;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] blue;
    logic [7:0] white;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  out_index;
    logic [31:0] word_green;
    logic [31:0] word_red;
    logic [31:0] word_blue;
    logic [31:0] word_white;
    logic [15:0] current_ma;
    logic        last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic             take_write;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             cnt_phase;
    logic             acc_clear;
    logic             mul_en;
    logic             out_load;
    logic [2:0]       out_status;
    logic [IDX_W-1:0] out_index;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic slot_free;
    logic over_budget;
  } dp_stat_t;

  // one channel byte to its 32-bit serial word, top pair in top byte
  function automatic logic [31:0] encode_byte(input logic [7:0] v);
    logic [31:0] w;
    w = '0;
    for (int p = 0; p < 4; p++) begin
      w[8*p +: 8] = PAIR_CODE[v[2*p +: 2]];
    end
    return w;
  endfunction

endpackage
`default_nettype wire

### src/rlfe_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module rlfe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

### src/rlfe_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module rlfe_ctrl #(
  parameter int MAX_LEDS = rlfe_pkg::MAX_LEDS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_kind,
  output logic                   in_ready,
  input  wire logic [5:0]        led_count,
  input  wire rlfe_pkg::dp_stat_t stat,
  output rlfe_pkg::dp_cmd_t      cmd
);
  import rlfe_pkg::*;

  localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int CW = $clog2(MAX_LEDS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CNT  = 3'd1;
  localparam logic [2:0] S_ACC  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_CMP  = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;
  localparam logic [2:0] S_TERM = 3'd6;

  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [CW-1:0] n_calc;
  logic          at_end;

  // leds walked by a render
  assign n_calc = (led_count < 6'(MAX_LEDS)) ? CW'(led_count) : CW'(MAX_LEDS);
  assign at_end = (CW'(idx_r) == (n_r - CW'(1)));

  // next state and commands
  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    n_nxt          = n_r;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.rd_addr    = IDX_W'(idx_r);
    cmd.out_index  = IDX_W'(idx_r);
    case (state_r)
      S_IDLE: begin
        in_ready = stat.slot_free;
        if (in_valid && stat.slot_free) begin
          if (in_kind == KIND_WRITE) begin
            cmd.take_write = 1'b1;
          end else begin
            cmd.acc_clear = 1'b1;
            n_nxt         = n_calc;
            idx_nxt       = '0;
            state_nxt     = (n_calc == '0) ? S_ACC : S_CNT;
          end
        end
      end
      S_CNT: begin
        cmd.rd_en     = 1'b1;
        cmd.cnt_phase = 1'b1;
        if (at_end) begin
          state_nxt = S_ACC;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      S_ACC: begin
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = S_CMP;
      end
      S_CMP: begin
        if (stat.over_budget) begin
          if (stat.slot_free) begin
            cmd.out_load   = 1'b1;
            cmd.out_status = ST_OVER;
            state_nxt      = S_IDLE;
          end
        end else if (n_r == '0) begin
          state_nxt = S_TERM;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = '0;
          idx_nxt     = '0;
          state_nxt   = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat.slot_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = ST_LED;
          if (at_end) begin
            state_nxt = S_TERM;
          end else begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = IDX_W'(idx_r + AW'(1));
            idx_nxt     = idx_r + AW'(1);
          end
        end
      end
      S_TERM: begin
        if (stat.slot_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = ST_TERM;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
      n_r     <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      n_r     <= n_nxt;
    end
  end

endmodule
`default_nettype wire

### src/rlfe_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module rlfe_datapath #(
  parameter int MAX_LEDS = rlfe_pkg::MAX_LEDS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire rlfe_pkg::in_item_t in_data,
  input  wire logic [5:0]         led_count,
  input  wire logic [7:0]         ma_per_channel,
  input  wire logic [15:0]        current_budget_ma,
  input  wire rlfe_pkg::dp_cmd_t  cmd,
  output rlfe_pkg::dp_stat_t      stat,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output rlfe_pkg::out_item_t     out_data
);
  import rlfe_pkg::*;

  localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;

  logic [MAX_LEDS-1:0] valid_r, valid_nxt;
  logic                rvalid_r;
  logic                acc_en_r;
  logic [7:0]          lit_r, lit_nxt;
  logic [15:0]         product_r;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r, out_data_nxt;
  logic [31:0]         rdata;
  logic [31:0]         entry;
  logic                in_range;
  logic                store_we;
  logic [2:0]          lit_add;

  // write range check against count and store depth
  assign in_range = (in_data.led_index < led_count) &&
                    (7'(in_data.led_index) < 7'(MAX_LEDS));
  assign store_we = cmd.take_write && in_range;

  rlfe_ram #(
    .WIDTH (32),
    .DEPTH (MAX_LEDS)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (in_data.led_index[AW-1:0]),
    .wdata ({in_data.green, in_data.red, in_data.blue, in_data.white}),
    .re    (cmd.rd_en),
    .raddr (cmd.rd_addr[AW-1:0]),
    .rdata (rdata)
  );

  // never-written entries read as zero
  always_comb begin
    valid_nxt = valid_r;
    if (store_we) begin
      valid_nxt[in_data.led_index[AW-1:0]] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rvalid_r <= 1'b0;
      acc_en_r <= 1'b0;
    end else begin
      valid_r  <= valid_nxt;
      acc_en_r <= cmd.rd_en && cmd.cnt_phase;
      if (cmd.rd_en) begin
        rvalid_r <= valid_r[cmd.rd_addr[AW-1:0]];
      end
    end
  end

  assign entry = rvalid_r ? rdata : '0;

  // lit channel count of the entry just read
  assign lit_add = 3'(entry[31:24] != '0) + 3'(entry[23:16] != '0) +
                   3'(entry[15:8] != '0) + 3'(entry[7:0] != '0);

  always_comb begin
    lit_nxt = lit_r;
    if (cmd.acc_clear) begin
      lit_nxt = '0;
    end else if (acc_en_r) begin
      lit_nxt = lit_r + 8'(lit_add);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lit_r <= '0;
    end else begin
      lit_r <= lit_nxt;
    end
  end

  // frame current estimate
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      product_r <= {8'd0, lit_r} * {8'd0, ma_per_channel};
    end
  end

  assign stat.over_budget = (product_r > current_budget_ma);
  assign stat.slot_free   = !out_valid_r || out_ready;

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.take_write) begin
      out_valid_nxt          = 1'b1;
      out_data_nxt           = '0;
      out_data_nxt.status    = in_range ? ST_WRITE_OK : ST_RANGE;
      out_data_nxt.out_index = in_data.led_index;
      out_data_nxt.last      = 1'b1;
    end else if (cmd.out_load) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt            = '0;
      out_data_nxt.status     = cmd.out_status;
      out_data_nxt.current_ma = product_r;
      if (cmd.out_status == ST_LED) begin
        out_data_nxt.out_index  = cmd.out_index;
        out_data_nxt.word_green = encode_byte(entry[31:24]);
        out_data_nxt.word_red   = encode_byte(entry[23:16]);
        out_data_nxt.word_blue  = encode_byte(entry[15:8]);
        out_data_nxt.word_white = encode_byte(entry[7:0]);
      end else begin
        out_data_nxt.last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

### src/rgbw_led_frame_encoder.sv
// write item: one result, registered, valid the cycle after acceptance; one write per cycle unless output stalls
// render item: n = min(led_count, MAX_LEDS) store reads count lit channels, then S_ACC,
//   S_MUL and S_CMP form and check the current; over budget gives one ST_OVER result, else n + 1
//   results at one per cycle while the output slot is free, from the single store read port
// reset: configuration returns to 32 leds, 20 mA, 25000 mA; every store entry reads as
//   zero at once through per-entry valid bits, no clearing pass
`timescale 1ns / 1ps
`default_nettype none
module rgbw_led_frame_encoder #(
  parameter int MAX_LEDS = rlfe_pkg::MAX_LEDS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire rlfe_pkg::in_item_t             in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output rlfe_pkg::out_item_t                 out_data,
  input  wire logic                           cfg_wr_en,
  input  wire logic [rlfe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rlfe_pkg::CFG_W-1:0]     cfg_data
);
  import rlfe_pkg::*;

  logic [5:0]  led_count_r;
  logic [7:0]  ma_per_ch_r;
  logic [15:0] budget_r;
  dp_cmd_t     cmd;
  dp_stat_t    stat;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_count_r <= LED_COUNT_RST;
      ma_per_ch_r <= MA_PER_CH_RST;
      budget_r    <= BUDGET_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_LED_COUNT: led_count_r <= cfg_data[5:0];
        CFG_MA_PER_CH: ma_per_ch_r <= cfg_data[7:0];
        CFG_BUDGET:    budget_r    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  rlfe_ctrl #(
    .MAX_LEDS (MAX_LEDS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_data.kind),
    .in_ready  (in_ready),
    .led_count (led_count_r),
    .stat      (stat),
    .cmd       (cmd)
  );

  rlfe_datapath #(
    .MAX_LEDS (MAX_LEDS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_data           (in_data),
    .led_count         (led_count_r),
    .ma_per_channel    (ma_per_ch_r),
    .current_budget_ma (budget_r),
    .cmd               (cmd),
    .stat              (stat),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_data          (out_data)
  );

endmodule
`default_nettype wire
